FILE: hw/rtl/crp_pkg.sv
// Types, codes and helper functions shared by the cell range reference parser.
package crp_pkg;

    // Fixed widths of the result fields.
    localparam int OUT_COL_W = 24;
    localparam int OUT_ROW_W = 32;

    localparam logic [7:0] CHAR_COLON = 8'h3A;
    localparam logic [7:0] CHAR_A     = 8'h41;
    localparam logic [7:0] CHAR_Z     = 8'h5A;
    localparam logic [7:0] CHAR_0     = 8'h30;
    localparam logic [7:0] CHAR_9     = 8'h39;

    typedef enum logic [2:0] {
        ERR_NONE     = 3'd0,
        ERR_FORMAT   = 3'd1,
        ERR_LETTER   = 3'd2,
        ERR_OVERFLOW = 3'd3,
        ERR_ZERO_ROW = 3'd4
    } err_kind_t;

    typedef enum logic [1:0] {
        PH_LETTERS = 2'd0,
        PH_DIGITS  = 2'd1,
        PH_TRAIL   = 2'd2
    } phase_t;

    typedef struct packed {
        phase_t phase;
        logic   seen_letters;
        logic   seen_digits;
        logic   letter_fault;
        logic   column_over;
        logic   row_over;
    } part_flags_t;

    localparam part_flags_t PART_CLEAR = '{
        phase:        PH_LETTERS,
        seen_letters: 1'b0,
        seen_digits:  1'b0,
        letter_fault: 1'b0,
        column_over:  1'b0,
        row_over:     1'b0
    };

    typedef struct packed {
        logic [7:0] char_byte;
        logic       last_char;
    } in_item_t;

    typedef struct packed {
        logic [OUT_COL_W-1:0] start_column;
        logic [OUT_ROW_W-1:0] start_row;
        logic [OUT_COL_W-1:0] end_column;
        logic [OUT_ROW_W-1:0] end_row;
        err_kind_t            error_kind;
    } out_item_t;

    // Error of one part, in priority order.
    function automatic err_kind_t part_error(input part_flags_t f, input logic row_zero);
        err_kind_t e;
        if (!f.seen_letters || !f.seen_digits) begin
            e = ERR_FORMAT;
        end else if (f.letter_fault) begin
            e = ERR_LETTER;
        end else if (f.column_over || f.row_over) begin
            e = ERR_OVERFLOW;
        end else if (row_zero) begin
            e = ERR_ZERO_ROW;
        end else begin
            e = ERR_NONE;
        end
        return e;
    endfunction

endpackage

FILE: hw/rtl/crp_char_step.sv
// One character applied to the column and row accumulators of a part.
module crp_char_step #(
    parameter int COL_BITS = 24,
    parameter int ROW_BITS = 32
) (
    input  logic [7:0]          char_byte,
    input  crp_pkg::part_flags_t flags_in,
    input  logic [COL_BITS-1:0] col_in,
    input  logic [ROW_BITS-1:0] row_in,
    output crp_pkg::part_flags_t flags_out,
    output logic [COL_BITS-1:0] col_out,
    output logic [ROW_BITS-1:0] row_out
);
    import crp_pkg::*;

    logic                is_digit;
    logic                is_upper;
    logic [ROW_BITS+3:0] row_ext;
    logic [ROW_BITS+3:0] row_cand;
    logic                row_ovf;
    logic [COL_BITS+4:0] col_ext;
    logic [COL_BITS+4:0] col_cand;
    logic                col_ovf;

    assign is_digit = (char_byte inside {[CHAR_0:CHAR_9]});
    assign is_upper = (char_byte inside {[CHAR_A:CHAR_Z]});

    // row * 10 + digit, overflow when anything lands above the row width
    assign row_ext  = {4'd0, row_in};
    assign row_cand = (row_ext << 3) + (row_ext << 1)
                    + {{ROW_BITS{1'b0}}, char_byte[3:0]};
    assign row_ovf  = (row_cand[ROW_BITS+3:ROW_BITS] != 4'd0);

    // column * 26 + letter value (A = 1)
    assign col_ext  = {5'd0, col_in};
    assign col_cand = (col_ext << 4) + (col_ext << 3) + (col_ext << 1)
                    + {{COL_BITS{1'b0}}, char_byte[4:0]};
    assign col_ovf  = (col_cand[COL_BITS+4:COL_BITS] != 5'd0);

    always_comb begin
        flags_out = flags_in;
        col_out   = col_in;
        row_out   = row_in;
        case (flags_in.phase)
            PH_LETTERS: begin
                if (is_digit) begin
                    flags_out.phase       = PH_DIGITS;
                    flags_out.seen_digits = 1'b1;
                    if (row_ovf) begin
                        flags_out.row_over = 1'b1;
                    end else begin
                        row_out = row_cand[ROW_BITS-1:0];
                    end
                end else begin
                    flags_out.seen_letters = 1'b1;
                    if (!is_upper) begin
                        flags_out.letter_fault = 1'b1;
                    end else if (!flags_in.letter_fault && !flags_in.column_over) begin
                        if (col_ovf) begin
                            flags_out.column_over = 1'b1;
                        end else begin
                            col_out = col_cand[COL_BITS-1:0];
                        end
                    end
                end
            end
            PH_DIGITS: begin
                if (is_digit) begin
                    flags_out.seen_digits = 1'b1;
                    if (!flags_in.row_over) begin
                        if (row_ovf) begin
                            flags_out.row_over = 1'b1;
                        end else begin
                            row_out = row_cand[ROW_BITS-1:0];
                        end
                    end
                end else begin
                    flags_out.phase = PH_TRAIL;
                end
            end
            PH_TRAIL: begin
                flags_out.phase = PH_TRAIL;
            end
            default: begin
                flags_out.phase = PH_TRAIL;
            end
        endcase
    end

endmodule

FILE: hw/rtl/cell_range_reference_parser.sv
// Top level of the spreadsheet cell and range reference parser.
//
// The block takes a reference string such as "B7" or "AA10:C3" one item
// (one byte plus a last flag) per cycle and, on the last byte, returns one
// result item with the start and end coordinates and an error code. The
// string splits at its first colon; each part is upper-case column letters
// (bijective base 26, A = 1) followed by decimal row digits, and text after
// the digits is ignored. A missing or empty end part copies the start. Any
// error zeroes all four coordinates; the start part is checked first.
// Columns above 2^COL_BITS-1 and rows above 2^ROW_BITS-1 report overflow;
// the reported coordinates are the accumulators cut or zero-extended to 24
// and 32 bits. The column and row accumulators update with a single
// shift-add multiply per byte, and the result register sits behind that
// logic, so a new item is accepted every cycle unless a finished result is
// stalled by m_ready. A result is registered and appears in the cycle after
// its last byte is accepted. No strings carry state into the next one: the
// parser returns to its reset state after every result.
module cell_range_reference_parser #(
    parameter int COL_BITS = 24,
    parameter int ROW_BITS = 32
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  crp_pkg::in_item_t   s_item,
    output logic                m_valid,
    input  logic                m_ready,
    output crp_pkg::out_item_t  m_item
);
    import crp_pkg::*;

    // Parser state for the part in progress and the saved start part.
    part_flags_t         flags_reg,     flags_next;
    logic [COL_BITS-1:0] col_reg,       col_next;
    logic [ROW_BITS-1:0] row_reg,       row_next;
    logic                end_seen_reg,  end_seen_next;
    logic [COL_BITS-1:0] saved_col_reg, saved_col_next;
    logic [ROW_BITS-1:0] saved_row_reg, saved_row_next;
    err_kind_t           pending_reg,   pending_next;

    // Result register.
    logic                m_valid_reg,   m_valid_next;
    out_item_t           m_item_reg,    m_item_next;

    // State after the current byte, before the end-of-string reset.
    part_flags_t         step_flags;
    logic [COL_BITS-1:0] step_col;
    logic [ROW_BITS-1:0] step_row;
    part_flags_t         upd_flags;
    logic [COL_BITS-1:0] upd_col;
    logic [ROW_BITS-1:0] upd_row;
    logic                upd_end_seen;
    logic [COL_BITS-1:0] upd_saved_col;
    logic [ROW_BITS-1:0] upd_saved_row;
    err_kind_t           upd_pending;

    logic                accept;
    logic                split;
    err_kind_t           res_err;
    logic [COL_BITS-1:0] res_sc, res_ec;
    logic [ROW_BITS-1:0] res_sr, res_er;
    logic [COL_BITS+OUT_COL_W-1:0] sc_wide, ec_wide;
    logic [ROW_BITS+OUT_ROW_W-1:0] sr_wide, er_wide;

    crp_char_step #(
        .COL_BITS (COL_BITS),
        .ROW_BITS (ROW_BITS)
    ) u_char_step (
        .char_byte (s_item.char_byte),
        .flags_in  (flags_reg),
        .col_in    (col_reg),
        .row_in    (row_reg),
        .flags_out (step_flags),
        .col_out   (step_col),
        .row_out   (step_row)
    );

    // Take a new item whenever the result register is empty or draining.
    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;
    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

    // Only the first colon splits the string; later ones are ordinary bytes.
    assign split = (s_item.char_byte == CHAR_COLON) && !end_seen_reg;

    always_comb begin
        if (split) begin
            upd_flags     = PART_CLEAR;
            upd_col       = '0;
            upd_row       = '0;
            upd_end_seen  = 1'b1;
            upd_saved_col = col_reg;
            upd_saved_row = row_reg;
            upd_pending   = part_error(flags_reg, row_reg == '0);
        end else begin
            upd_flags     = step_flags;
            upd_col       = step_col;
            upd_row       = step_row;
            upd_end_seen  = end_seen_reg;
            upd_saved_col = saved_col_reg;
            upd_saved_row = saved_row_reg;
            upd_pending   = pending_reg;
        end
    end

    // Assemble the result from the updated state.
    always_comb begin
        if (!upd_end_seen) begin
            res_err = part_error(upd_flags, upd_row == '0);
            res_sc  = upd_col;
            res_sr  = upd_row;
            res_ec  = upd_col;
            res_er  = upd_row;
        end else begin
            res_err = upd_pending;
            res_sc  = upd_saved_col;
            res_sr  = upd_saved_row;
            res_ec  = upd_saved_col;
            res_er  = upd_saved_row;
            // An empty end part keeps the start; otherwise check and use it.
            if (upd_pending == ERR_NONE
                && (upd_flags.seen_letters || upd_flags.seen_digits)) begin
                res_err = part_error(upd_flags, upd_row == '0);
                res_ec  = upd_col;
                res_er  = upd_row;
            end
        end
        // Drop all coordinates on any error.
        if (res_err != ERR_NONE) begin
            res_sc = '0;
            res_sr = '0;
            res_ec = '0;
            res_er = '0;
        end
    end

    assign sc_wide = {{OUT_COL_W{1'b0}}, res_sc};
    assign ec_wide = {{OUT_COL_W{1'b0}}, res_ec};
    assign sr_wide = {{OUT_ROW_W{1'b0}}, res_sr};
    assign er_wide = {{OUT_ROW_W{1'b0}}, res_er};

    always_comb begin
        flags_next     = flags_reg;
        col_next       = col_reg;
        row_next       = row_reg;
        end_seen_next  = end_seen_reg;
        saved_col_next = saved_col_reg;
        saved_row_next = saved_row_reg;
        pending_next   = pending_reg;
        m_valid_next   = m_valid_reg;
        m_item_next    = m_item_reg;

        // Retire the held result once it is taken.
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        if (accept) begin
            if (s_item.last_char) begin
                // Emit the result and return to the reset state.
                m_valid_next              = 1'b1;
                m_item_next.start_column  = sc_wide[OUT_COL_W-1:0];
                m_item_next.start_row     = sr_wide[OUT_ROW_W-1:0];
                m_item_next.end_column    = ec_wide[OUT_COL_W-1:0];
                m_item_next.end_row       = er_wide[OUT_ROW_W-1:0];
                m_item_next.error_kind    = res_err;
                flags_next     = PART_CLEAR;
                col_next       = '0;
                row_next       = '0;
                end_seen_next  = 1'b0;
                saved_col_next = '0;
                saved_row_next = '0;
                pending_next   = ERR_NONE;
            end else begin
                flags_next     = upd_flags;
                col_next       = upd_col;
                row_next       = upd_row;
                end_seen_next  = upd_end_seen;
                saved_col_next = upd_saved_col;
                saved_row_next = upd_saved_row;
                pending_next   = upd_pending;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            flags_reg     <= PART_CLEAR;
            col_reg       <= '0;
            row_reg       <= '0;
            end_seen_reg  <= 1'b0;
            saved_col_reg <= '0;
            saved_row_reg <= '0;
            pending_reg   <= ERR_NONE;
            m_valid_reg   <= 1'b0;
        end else begin
            flags_reg     <= flags_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            end_seen_reg  <= end_seen_next;
            saved_col_reg <= saved_col_next;
            saved_row_reg <= saved_row_next;
            pending_reg   <= pending_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    // Payload needs no reset.
    always_ff @(posedge aclk) begin
        m_item_reg <= m_item_next;
    end

endmodule

FILE: hw/rtl/crp_checker.sv
// Port-level assertions for the cell range reference parser, bound to the top level.
module crp_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input crp_pkg::in_item_t  s_item,
    input logic               m_valid,
    input logic               m_ready,
    input crp_pkg::out_item_t m_item
);
    import crp_pkg::*;

    // A stalled result stays up.
    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result dropped while stalled");

    // The last byte of a string always yields a result next cycle.
    a_last_yields_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_item.last_char |=> m_valid)
        else $error("no result after last byte");

    // A byte that is not last yields nothing new.
    a_no_spurious_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && !s_item.last_char && !(m_valid && !m_ready) |=> !m_valid)
        else $error("result without last byte");

    // An errored result carries zero coordinates.
    a_error_zeroes: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_item.error_kind != ERR_NONE |->
            m_item.start_column == '0 && m_item.start_row == '0
            && m_item.end_column == '0 && m_item.end_row == '0)
        else $error("nonzero coordinates on error");

    // With no result pending, the input is never held off.
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with empty output");

endmodule

bind cell_range_reference_parser crp_checker u_crp_checker (.*);
